>>> rtl/core/zrle_pkg.sv
// Shared constants for the zero run-length encoder.
package zrle_pkg;

	// Default width of the zero-run counter, and the hard ceiling on it.
	localparam int RUN_COUNT_BITS_DEF = 31;
	localparam int STATE_BITS         = 31;

	// Bytes at or above the escape base are sent as an escape pair.
	localparam logic [7:0] ESC_BASE = 8'hFE;
	localparam logic [7:0] ESC_CODE = 8'hFF;

endpackage

>>> rtl/core/zero_run_length_encoder.sv
// Zero run-length encoder: bijective binary coding of zero runs, escaped bytes.
// Sequencing: an accepted plain nonzero byte with no pending run moves the sequencer to its
// byte state, from which the byte code is registered into the output beat; an escape adds a
// second beat from the escape state. A run flush first normalises the code N+1 in a shared
// shift register, one position per cycle, then sends one run bit per cycle while the output
// is not stalled, before any byte code. Zero bytes that only extend the run keep input ready.
// Reset (arst_n low, asynchronous) clears the run count, the sequencer and the output valid.
module zero_run_length_encoder
	import zrle_pkg::*;
#(
	parameter int RUN_COUNT_BITS = RUN_COUNT_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       block_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] code_byte,
	output logic       last_of_run
);

	localparam int CW = (RUN_COUNT_BITS < STATE_BITS) ? RUN_COUNT_BITS : STATE_BITS;
	localparam int SW = CW + 1;
	localparam int RW = $clog2(SW + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_RUN  = 3'd2;
	localparam logic [2:0] ST_BYTE = 3'd3;
	localparam logic [2:0] ST_ESC2 = 3'd4;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] shift_q;
	logic [RW-1:0] rem_q;
	logic [7:0]    data_q;
	logic          has_byte_q;
	logic          out_valid_q;
	logic [7:0]    code_q;
	logic          last_q;

	logic          accept;
	logic          slot_free;
	logic          emit;
	logic [CW-1:0] count_inc;
	logic [SW-1:0] run_code;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign slot_free   = !out_valid_q || out_ready;
	assign emit        = slot_free &&
		(state_q == ST_RUN || state_q == ST_BYTE || state_q == ST_ESC2);
	assign out_valid   = out_valid_q;
	assign code_byte   = code_q;
	assign last_of_run = last_q;

	// The counter saturates rather than wrapping.
	assign count_inc = (count_q == {CW{1'b1}}) ? count_q : count_q + {{(CW-1){1'b0}}, 1'b1};

	always_comb begin
		if (data_byte == 8'd0) begin
			run_code = {1'b0, count_inc} + {{CW{1'b0}}, 1'b1};
		end else begin
			run_code = {1'b0, count_q} + {{CW{1'b0}}, 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			has_byte_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (data_byte == 8'd0) begin
							if (block_end) begin
								count_q    <= '0;
								has_byte_q <= 1'b0;
								rem_q      <= RW'(SW);
								state_q    <= ST_NORM;
							end else begin
								count_q <= count_inc;
							end
						end else begin
							count_q    <= '0;
							has_byte_q <= 1'b1;
							rem_q      <= RW'(SW);
							state_q    <= (count_q != '0) ? ST_NORM : ST_BYTE;
						end
					end
				end
				ST_NORM: begin
					// Shift until the leading one leaves; what remains are the run bits.
					rem_q <= rem_q - {{(RW-1){1'b0}}, 1'b1};
					if (shift_q[SW-1]) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (slot_free) begin
						rem_q <= rem_q - {{(RW-1){1'b0}}, 1'b1};
						if (rem_q == {{(RW-1){1'b0}}, 1'b1}) begin
							state_q <= has_byte_q ? ST_BYTE : ST_IDLE;
						end
					end
				end
				ST_BYTE: begin
					if (slot_free) begin
						state_q <= (data_q >= ESC_BASE) ? ST_ESC2 : ST_IDLE;
					end
				end
				ST_ESC2: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: shared shift register, held byte and output beat.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					shift_q <= run_code;
					data_q  <= data_byte;
				end
			end
			ST_NORM: begin
				shift_q <= shift_q << 1;
			end
			ST_RUN: begin
				if (slot_free) begin
					code_q  <= {7'd0, shift_q[SW-1]};
					last_q  <= (rem_q == {{(RW-1){1'b0}}, 1'b1}) && !has_byte_q;
					shift_q <= shift_q << 1;
				end
			end
			ST_BYTE: begin
				if (slot_free) begin
					if (data_q >= ESC_BASE) begin
						code_q <= ESC_CODE;
						last_q <= 1'b0;
					end else begin
						code_q <= data_q + 8'd1;
						last_q <= 1'b1;
					end
				end
			end
			ST_ESC2: begin
				if (slot_free) begin
					code_q <= data_q - ESC_BASE;
					last_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/zrle_checker.sv
// Port-level checker for the zero run-length encoder, with its bind.
module zrle_checker
	import zrle_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] data_byte,
	input logic       block_end,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] code_byte,
	input logic       last_of_run
);

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_byte) && $stable(last_of_run))
		else $error("output beat changed while stalled");

	// An escape byte is followed at once by its final remainder beat.
	a_esc_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && code_byte == ESC_CODE && !last_of_run
		|=> out_valid && last_of_run && code_byte[7:1] == 7'd0)
		else $error("escape byte not followed by its remainder");

	// Only run bits and the escape byte may precede the final beat of an item.
	a_nonlast_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> code_byte[7:1] == 7'd0 || code_byte == ESC_CODE)
		else $error("unexpected code on a non-final beat");

	// A nonzero byte always produces output, so the input stalls behind it.
	a_busy_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && data_byte != 8'd0 |=> !in_ready)
		else $error("input taken while a byte was still being coded");

	// A zero byte inside a block only extends the run, so the input stays open.
	a_zero_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && data_byte == 8'd0 && !block_end |=> in_ready)
		else $error("input closed after a zero byte inside a block");

endmodule

bind zero_run_length_encoder zrle_checker u_zrle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.data_byte   (data_byte),
	.block_end   (block_end),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.code_byte   (code_byte),
	.last_of_run (last_of_run)
);
